// ----- hw/rtl/stig_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stig_pkg;

  // Geometry limits of the line buffers
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Field widths fixed by the interface
  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 9;
  localparam int DIM_W   = 11;
  localparam int CFG_IDX_W = 2;

  // Up to three results per input pixel
  localparam int RES_MAX   = 3;
  localparam int RES_N_W   = $clog2(RES_MAX + 1);
  localparam int FIFO_DEPTH = 4;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_t;

  // One line buffer entry per column: row above, two rows above, temporal diff above
  typedef struct packed {
    pix_t  above;
    pix_t  above2;
    grad_t td;
  } line_entry_t;

  localparam int ENTRY_W = $bits(line_entry_t);

  // Position of the pixel being processed
  typedef struct packed {
    logic first_col;
    logic second_col;
    logic last_col;
    logic row_valid;
    logic second_row;
    logic last_row;
  } pos_flags_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    grad_t            grad_horiz;
    grad_t            grad_vert;
    grad_t            grad_time;
    logic             frame_last;
  } result_t;

  // Clamp a written width to [2, MAX_WIDTH] and return the last column index
  function automatic logic [COL_W-1:0] width_last(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] t;
    if (v < DIM_W'(2)) begin
      t = DIM_W'(2);
    end else if (v > DIM_W'(MAX_WIDTH)) begin
      t = DIM_W'(MAX_WIDTH);
    end else begin
      t = v;
    end
    return COL_W'(t - DIM_W'(1));
  endfunction

  function automatic logic [ROW_W-1:0] height_last(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] t;
    if (v < DIM_W'(2)) begin
      t = DIM_W'(2);
    end else if (v > DIM_W'(MAX_HEIGHT)) begin
      t = DIM_W'(MAX_HEIGHT);
    end else begin
      t = v;
    end
    return ROW_W'(t - DIM_W'(1));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stig_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire                      rd_en,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stig_grad.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stig_grad
  import stig_pkg::*;
(
  input  pos_flags_t        flags,
  input  wire  [COL_W-1:0]  col,
  input  wire  [ROW_W-1:0]  row,
  input  pix_t              cur,
  input  grad_t             td,
  input  pix_t              above,
  input  pix_t              above2,
  input  grad_t             td_above,
  input  pix_t              right,
  input  pix_t              left,
  input  pix_t              recent0,
  input  pix_t              recent1,
  input  grad_t             recent_td,
  output result_t           res [RES_MAX],
  output logic [RES_N_W-1:0] res_n
);

  grad_t gh_a, gv_a, gh_b;

  always_comb begin
    if (flags.first_col) begin
      gh_a = grad_t'({1'b0, right});
    end else if (flags.last_col) begin
      gh_a = grad_t'({1'b0, left});
    end else begin
      gh_a = grad_t'({1'b0, right}) - grad_t'({1'b0, left});
    end

    if (flags.second_row) begin
      gv_a = grad_t'({1'b0, cur});
    end else begin
      gv_a = grad_t'({1'b0, cur}) - grad_t'({1'b0, above2});
    end

    if (flags.second_col) begin
      gh_b = grad_t'({1'b0, cur});
    end else begin
      gh_b = grad_t'({1'b0, cur}) - grad_t'({1'b0, recent1});
    end

    // row above, this column
    res[0].col        = col;
    res[0].row        = row - ROW_W'(1);
    res[0].grad_horiz = gh_a;
    res[0].grad_vert  = gv_a;
    res[0].grad_time  = td_above;
    res[0].frame_last = 1'b0;

    // last row, previous column
    res[1].col        = col - COL_W'(1);
    res[1].row        = row;
    res[1].grad_horiz = gh_b;
    res[1].grad_vert  = grad_t'({1'b0, left});
    res[1].grad_time  = recent_td;
    res[1].frame_last = 1'b0;

    // last row, last column: closes the frame
    res[2].col        = col;
    res[2].row        = row;
    res[2].grad_horiz = grad_t'({1'b0, recent0});
    res[2].grad_vert  = grad_t'({1'b0, above});
    res[2].grad_time  = td;
    res[2].frame_last = 1'b1;

    if (!flags.row_valid) begin
      res_n = RES_N_W'(0);
    end else if (!flags.last_row || flags.first_col) begin
      res_n = RES_N_W'(1);
    end else if (flags.last_col) begin
      res_n = RES_N_W'(3);
    end else begin
      res_n = RES_N_W'(2);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stig_rfifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stig_rfifo
  import stig_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire  [RES_N_W-1:0]  push_n,
  input  result_t             push_res [RES_MAX],
  output logic                room,
  input  wire                 pop,
  output logic                head_valid,
  output result_t             head
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t          entry_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W:0]   fill_sum;

  assign fill_sum   = {1'b0, count_r} + (CNT_W+1)'(push_n);
  assign room       = fill_sum <= (CNT_W+1)'(FIFO_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
      count_nxt  = count_nxt + CNT_W'(push_n);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
      count_nxt  = count_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (push && (RES_N_W'(k) < push_n)) begin
        entry_r[wr_ptr_r + PTR_W'(k)] <= push_res[k];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/spatiotemporal_image_gradient_top.sv -----
// A pixel accepted is registered into stage 1; its results then pass the result queue.
// Throughput: one pixel per cycle while in_stall is low, set by the single line-buffer
// write per column; in the last row each pixel past the first column yields two results
// (three on the final pixel), so there the one-result-per-cycle output port stalls input.
// Reset: clears scan position, pipeline and result queue, geometry to 1024 x 1024; the
// line buffer keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module spatiotemporal_image_gradient_top
  import stig_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  // configuration
  input  wire                  cfg_wr_en,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [DIM_W-1:0]     cfg_data,
  // pixel pairs in
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [PIX_W-1:0]     in_pixel_first,
  input  wire  [PIX_W-1:0]     in_pixel_second,
  // gradient results out
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [COL_W-1:0]     out_col,
  output logic [ROW_W-1:0]     out_row,
  output logic [GRAD_W-1:0]    out_grad_horiz,
  output logic [GRAD_W-1:0]    out_grad_vert,
  output logic [GRAD_W-1:0]    out_grad_time,
  output logic                 out_frame_last
);

  // ---------------------------------------------------------------------------
  // Geometry and scan position
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] width_last_r, width_last_nxt;
  logic [ROW_W-1:0] height_last_r, height_last_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             cfg_restart;

  logic             accept;
  logic             s1_go;

  // Decode a geometry write; either register restarts the scan. Unknown indexes do nothing.
  always_comb begin
    width_last_nxt  = width_last_r;
    height_last_nxt = height_last_r;
    cfg_restart     = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          width_last_nxt = width_last(cfg_data);
          cfg_restart    = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          height_last_nxt = height_last(cfg_data);
          cfg_restart     = 1'b1;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  // Advance raster position per accepted transaction; column is the fast index
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == width_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == height_last_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= COL_W'(MAX_WIDTH - 1);
      height_last_r <= ROW_W'(MAX_HEIGHT - 1);
      col_r         <= '0;
      row_r         <= '0;
    end else begin
      width_last_r  <= width_last_nxt;
      height_last_r <= height_last_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0 -> stage 1: input register alongside the line-buffer read
  // ---------------------------------------------------------------------------
  logic        s1_valid_r, s1_valid_nxt;
  pix_t        s1_cur_r;
  grad_t       s1_td_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  pos_flags_t  s1_flags_r;
  pos_flags_t  s0_flags;
  grad_t       s0_td;

  // Forwarding of a write that lands on the same edge as the read
  logic        hit_a_r, hit_b_r;
  line_entry_t fwd_r;

  // Take a transaction whenever stage 1 is empty or emptying this cycle
  assign in_stall = s1_valid_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  assign s0_td = grad_t'({1'b0, in_pixel_second}) - grad_t'({1'b0, in_pixel_first});

  always_comb begin
    s0_flags.first_col  = col_r == '0;
    s0_flags.second_col = col_r == COL_W'(1);
    s0_flags.last_col   = col_r == width_last_r;
    s0_flags.row_valid  = row_r != '0;
    s0_flags.second_row = row_r == ROW_W'(1);
    s0_flags.last_row   = row_r == height_last_r;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Line buffer: read this column and the next, write back from stage 1
  logic [ENTRY_W-1:0] ram_rd_a, ram_rd_b;
  logic [COL_W-1:0]   rd_addr_b;
  line_entry_t        wr_entry;
  line_entry_t        entry_a, entry_b;

  assign rd_addr_b = col_r + COL_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r   <= in_pixel_first;
      s1_td_r    <= s0_td;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_flags_r <= s0_flags;
      hit_a_r    <= s1_go && (s1_col_r == col_r);
      hit_b_r    <= s1_go && (s1_col_r == rd_addr_b);
      fwd_r      <= wr_entry;
    end
  end

  stig_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (s1_go),
    .wr_addr   (s1_col_r),
    .wr_data   (wr_entry),
    .rd_en     (accept),
    .rd_addr_a (col_r),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ram_rd_a),
    .rd_data_b (ram_rd_b)
  );

  assign entry_a = hit_a_r ? fwd_r : line_entry_t'(ram_rd_a);
  assign entry_b = hit_b_r ? fwd_r : line_entry_t'(ram_rd_b);

  // Push the row down one line: current pixel becomes "above", old above becomes "above2"
  assign wr_entry.above  = s1_cur_r;
  assign wr_entry.above2 = entry_a.above;
  assign wr_entry.td     = s1_td_r;

  // ---------------------------------------------------------------------------
  // Stage 1: gradients, history of the current row
  // ---------------------------------------------------------------------------
  pix_t  prev_above_r;
  pix_t  recent0_r, recent1_r;
  grad_t recent_td_r;

  result_t          res [RES_MAX];
  logic [RES_N_W-1:0] res_n;
  logic             fifo_room;

  stig_grad u_grad (
    .flags     (s1_flags_r),
    .col       (s1_col_r),
    .row       (s1_row_r),
    .cur       (s1_cur_r),
    .td        (s1_td_r),
    .above     (entry_a.above),
    .above2    (entry_a.above2),
    .td_above  (entry_a.td),
    .right     (entry_b.above),
    .left      (prev_above_r),
    .recent0   (recent0_r),
    .recent1   (recent1_r),
    .recent_td (recent_td_r),
    .res       (res),
    .res_n     (res_n)
  );

  // Retire stage 1 only when the queue can hold all of its results at once
  assign s1_go = s1_valid_r && fifo_room;

  // Hold row history until the transaction retires
  always_ff @(posedge clk) begin
    if (s1_go) begin
      prev_above_r <= entry_a.above;
      recent1_r    <= recent0_r;
      recent0_r    <= s1_cur_r;
      recent_td_r  <= s1_td_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: absorbs the two-or-three result bursts of the last row
  // ---------------------------------------------------------------------------
  result_t head;
  logic    head_valid;

  stig_rfifo u_rfifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_go),
    .push_n     (res_n),
    .push_res   (res),
    .room       (fifo_room),
    .pop        (head_valid && !out_stall),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_valid      = head_valid;
  assign out_col        = head.col;
  assign out_row        = head.row;
  assign out_grad_horiz = head.grad_horiz;
  assign out_grad_vert  = head.grad_vert;
  assign out_grad_time  = head.grad_time;
  assign out_frame_last = head.frame_last;

endmodule

`default_nettype wire
